FILE: rtl/lpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants
// Request/response structs, codes and table geometry for the hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // Table geometry. The home slot is taken as the low index bits of the key,
  // so the depth is kept a power of two.
  localparam int unsigned TABLE_DEPTH = 128;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KEY_W       = 31;
  localparam int unsigned DATA_W      = 32;

  // Keys below this are reserved.
  localparam logic [KEY_W-1:0] KEY_FIRST_VALID = KEY_W'(2);

  typedef enum logic [1:0] {
    CMD_FIND   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_MISS    = 3'd1,
    STS_DUP     = 3'd2,
    STS_FULL    = 3'd3,
    STS_BAD_KEY = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_USED  = 2'd1,
    TAG_GONE  = 2'd2
  } tag_e;

  typedef struct packed {
    cmd_e                      command;
    logic [KEY_W-1:0]          key;
    logic signed [DATA_W-1:0]  data_in;
  } req_t;

  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  data_out;
  } rsp_t;

  // One stored slot.
  typedef struct packed {
    tag_e                      tag;
    logic [KEY_W-1:0]          key;
    logic signed [DATA_W-1:0]  value;
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_READ  = 2'd1,
    ST_CHECK = 2'd2
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // latch request, point at home slot
    logic read;     // read the current probe slot
    logic advance;  // step to the next slot
    logic finish;   // commit result and table update
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic done;      // current probe ends the request
    logic out_free;  // output register can take a response
  } dp_stat_t;

endpackage

FILE: rtl/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table: open-addressing hash table, linear probing
// Find, insert, delete and clear requests on a 128-slot table with
// tombstones; one response per request.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ------------------------
//  request   in         in_valid_i / in_stall_o   in_req_i   (req_t)
//  response  out        out_valid_o / out_stall_i out_rsp_o  (rsp_t)
//
// Probes: a request probes from 1 up to depth+1 slots.
//   Each probe is a registered read of the single-port slot memory followed
//   by a check step. Clear and reserved keys resolve in a single probe.
// Reset: tags read as empty through per-slot valid bits cleared by reset;
//   no clearing pass, the clear command wipes them all together.
// Stalls: the response sits in an output register; a new request is taken
//   while it waits. A finished request holds in the check step until that
//   register is free.
//
module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  // sequencer: idle -> read -> check (-> read ...) -> idle
  lpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  // slot store, probe walk and response register
  lpht_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

FILE: rtl/lpht_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ctrl: request sequencer
// Steps each request through slot reads and checks until it completes.
// ----------------------------------------------------------------------------
module lpht_ctrl
  import lpht_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat_i.done) begin
          // hold here until the response can be parked
          if (stat_i.out_free) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/lpht_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_datapath: slot store and probe logic
// Slot memory, per-slot valid bits, probe pointer and counter, response reg.
// ----------------------------------------------------------------------------
module lpht_datapath
  import lpht_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  req_t      in_req_i,
  input  ctrl_cmd_t cmd_i,
  output dp_stat_t  stat_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output rsp_t      out_rsp_o
);

  slot_t                   mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  slot_valid_q;

  req_t                    req_q;
  logic [IDX_W-1:0]        probe_q;
  logic [CNT_W-1:0]        cnt_q;
  slot_t                   rd_q;
  logic                    rd_valid_q;

  logic                    out_valid_q;
  rsp_t                    out_rsp_q;

  // probe evaluation
  tag_e    cur_tag;
  logic    is_used, is_empty, key_hit, last_probe;
  logic    is_clear, bad_key, is_insert, is_find;
  logic    done;
  status_e sts;
  logic    ins_write, del_write;
  slot_t   wr_slot;
  logic    we;
  logic [IDX_W-1:0] next_probe;

  always_comb begin
    cur_tag    = rd_valid_q ? rd_q.tag : TAG_EMPTY;
    is_used    = (cur_tag == TAG_USED);
    is_empty   = (cur_tag == TAG_EMPTY);
    key_hit    = is_used && (rd_q.key == req_q.key);
    last_probe = (cnt_q == CNT_W'(TABLE_DEPTH));
    is_clear   = (req_q.command == CMD_CLEAR);
    is_insert  = (req_q.command == CMD_INSERT);
    is_find    = (req_q.command == CMD_FIND);
    bad_key    = (req_q.key < KEY_FIRST_VALID);

    done      = 1'b1;
    sts       = STS_OK;
    ins_write = 1'b0;
    del_write = 1'b0;
    if (is_clear) begin
      sts = STS_OK;
    end else if (bad_key) begin
      sts = STS_BAD_KEY;
    end else if (is_insert) begin
      if (!is_used) begin
        ins_write = 1'b1;
      end else if (key_hit) begin
        sts = STS_DUP;
      end else if (last_probe) begin
        sts = STS_FULL;
      end else begin
        done = 1'b0;
      end
    end else begin
      // find and delete: tombstones are skipped
      if (is_empty) begin
        sts = STS_MISS;
      end else if (key_hit) begin
        del_write = !is_find;
      end else if (last_probe) begin
        sts = STS_MISS;
      end else begin
        done = 1'b0;
      end
    end

    wr_slot = rd_q;
    if (ins_write) begin
      wr_slot.tag   = TAG_USED;
      wr_slot.key   = req_q.key;
      wr_slot.value = req_q.data_in;
    end else begin
      wr_slot.tag = TAG_GONE;
    end
    we = cmd_i.finish && (ins_write || del_write);

    next_probe = (probe_q == IDX_W'(TABLE_DEPTH - 1)) ? '0 : probe_q + 1'b1;
  end

  assign stat_o.done     = done;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  // slot memory: one write, one registered read, both at the probe pointer
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[probe_q] <= wr_slot;
    end
    if (cmd_i.read) begin
      rd_q <= mem[probe_q];
    end
  end

  // request, pointer, counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= in_req_i;
      probe_q <= in_req_i.key[IDX_W-1:0];
      cnt_q   <= '0;
    end else if (cmd_i.advance) begin
      probe_q <= next_probe;
      cnt_q   <= cnt_q + 1'b1;
    end
  end

  // valid bits stand in for the tag reset; clear wipes them all together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      rd_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.read) begin
        rd_valid_q <= slot_valid_q[probe_q];
      end
      if (cmd_i.finish && is_clear) begin
        slot_valid_q <= '0;
      end else if (cmd_i.finish && ins_write) begin
        slot_valid_q[probe_q] <= 1'b1;
      end
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_rsp_q.status   <= sts;
      out_rsp_q.data_out <= (is_find && !is_clear && !bad_key && key_hit)
                            ? rd_q.value : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
